// ===== hw/rtl/tlmd_pkg.sv =====
// shared types, constants and helpers of the two-line modulated diffuser
package tlmd_pkg;

    localparam int LINE_DEPTH = 8192;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int SMP_W      = 24;
    localparam int MOD_SHIFT  = SMP_W - 1 - 15;

    localparam logic [ADDR_W-1:0] TAP_MAX = ADDR_W'(LINE_DEPTH - 1);

    // tap dividends after the power-of-two part of the divisor is shifted out
    localparam int NA_W  = 22;
    localparam int NB_W  = 29;
    // floor(n / 125) and floor(n / 15625) by reciprocal multiplication
    localparam int QSH_A = 29;
    localparam int QSH_B = 43;
    localparam logic [22:0] RECIP_A = 23'd4294968;
    localparam logic [29:0] RECIP_B = 30'd562949954;

    localparam logic [1:0] REG_SIZE = 2'd0;
    localparam logic [1:0] REG_FS   = 2'd1;
    localparam logic [1:0] REG_FB   = 2'd2;
    localparam logic [1:0] REG_MIX  = 2'd3;

    typedef struct packed {
        logic [9:0]         size_ms_q4;
        logic [17:0]        sample_rate_hz;
        logic signed [15:0] feedback_q15;
        logic [15:0]        mix_q15;
    } t_cfg;

    typedef struct packed {
        logic signed [SMP_W-1:0] x;
        logic signed [15:0]      m15;
    } t_item;

    function automatic logic signed [SMP_W-1:0] sat_smp(input logic signed [31:0] v);
        logic signed [31:0] hi;
        logic signed [31:0] lo;
        hi = 32'sd2 ** (SMP_W - 1) - 32'sd1;
        lo = -(32'sd2 ** (SMP_W - 1));
        if (v > hi) begin
            return SMP_W'(hi);
        end else if (v < lo) begin
            return SMP_W'(lo);
        end
        return SMP_W'(v);
    endfunction

endpackage

// ===== hw/rtl/tlmd_front.sv =====
// front end: takes input transactions, derives q1.15 modulation, queues them
module tlmd_front import tlmd_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  logic signed [SMP_W-1:0] i_audio_in,
    input  logic signed [SMP_W-1:0] i_mod_in,
    output logic                    o_qfull,
    output logic                    o_qvalid,
    output t_item                   o_item,
    input  logic                    i_qpop
);

    t_item       r_q [2];
    logic [1:0]  r_cnt;
    logic        r_wr;
    logic        r_rd;
    logic        push_ok;
    logic        pop_ok;
    t_item       item_in;

    assign o_qfull  = (r_cnt == 2'd2);
    assign o_qvalid = (r_cnt != 2'd0);
    assign o_item   = r_q[r_rd];
    assign push_ok  = i_push && !o_qfull;
    assign pop_ok   = i_qpop && o_qvalid;

    // floor of mod / 2^shift gives the modulation in q1.15
    assign item_in.x   = i_audio_in;
    assign item_in.m15 = 16'(i_mod_in >>> MOD_SHIFT);

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wr] <= item_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
        end else begin
            if (push_ok) begin
                r_wr <= ~r_wr;
            end
            if (pop_ok) begin
                r_rd <= ~r_rd;
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

// ===== hw/rtl/tlmd_back.sv =====
// back end: tap computation, delay lines, rotation, feedback and output blend
module tlmd_back import tlmd_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  logic                    i_qvalid,
    input  t_item                   i_item,
    output logic                    o_qpop,
    output logic                    o_clearing,
    output logic                    o_valid,
    output logic signed [SMP_W-1:0] o_audio_out,
    input  logic                    i_pop
);

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_PREP = 11'b00000000010,
        S_MUL2 = 11'b00000000100,
        S_MUL3 = 11'b00000001000,
        S_DIV  = 11'b00000010000,
        S_RD   = 11'b00000100000,
        S_SD   = 11'b00001000000,
        S_ROT  = 11'b00010000000,
        S_FB   = 11'b00100000000,
        S_WR   = 11'b01000000000,
        S_OUT  = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    logic signed [SMP_W-1:0] line_a [LINE_DEPTH];
    logic signed [SMP_W-1:0] line_b [LINE_DEPTH];

    logic                    r_clearing;
    logic [ADDR_W-1:0]       r_clr_addr;
    logic [ADDR_W-1:0]       r_wp;

    logic signed [SMP_W-1:0] r_x;
    logic signed [15:0]      r_m15;
    logic signed [15:0]      r_fb;
    logic [15:0]             r_mix;
    logic [17:0]             r_fs;
    logic [26:0]             r_p1;
    logic [44:0]             r_prod;
    logic [NA_W-1:0]         r_na;
    logic [NB_W-1:0]         r_nb;
    logic [15:0]             r_qa, r_qb;
    logic signed [SMP_W-1:0] r_rda, r_rdb;
    logic signed [SMP_W:0]   r_s, r_d;
    logic signed [SMP_W:0]   r_sum, r_diff;
    logic signed [40:0]      r_pa, r_pb;
    logic signed [41:0]      r_pw;
    logic signed [26:0]      r_wet;
    logic                    r_valid;
    logic signed [SMP_W-1:0] r_out;

    // combinational helpers
    logic [9:0]              size_c;
    logic [17:0]             fs_c;
    logic [16:0]             scale;
    logic signed [15:0]      fb0;
    logic signed [30:0]      fbm;
    logic signed [17:0]      fbt;
    logic signed [17:0]      mixt;
    logic [55:0]             pbig;
    logic [44:0]             qa_full;
    logic [58:0]             qb_full;
    logic [ADDR_W-1:0]       tap_a, tap_b;
    logic [ADDR_W-1:0]       raddr_a, raddr_b;
    logic signed [40:0]      ps, pd;
    logic signed [26:0]      na, nb;
    logic signed [40:0]      pdry;
    logic signed [43:0]      pwet;
    logic signed [44:0]      ysum;
    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_wa;
    logic signed [SMP_W-1:0] wd_a, wd_b;
    logic                    out_free;

    assign o_clearing  = r_clearing;
    assign o_valid     = r_valid;
    assign o_audio_out = r_out;
    assign o_qpop      = (r_state == S_IDLE) && !r_clearing && i_qvalid;
    assign out_free    = !r_valid || i_pop;

    always_comb begin
        size_c = (i_cfg.size_ms_q4 < 10'd8) ? 10'd8 :
                 (i_cfg.size_ms_q4 > 10'd960) ? 10'd960 : i_cfg.size_ms_q4;
        fs_c   = (i_cfg.sample_rate_hz < 18'd1) ? 18'd1 :
                 (i_cfg.sample_rate_hz > 18'd192000) ? 18'd192000 : i_cfg.sample_rate_hz;
        scale  = 17'(18'sd65536 + 18'(r_m15));
        fb0    = (i_cfg.feedback_q15 > 16'sd32440) ? 16'sd32440 :
                 (i_cfg.feedback_q15 < -16'sd32440) ? -16'sd32440 : i_cfg.feedback_q15;
        fbm    = 31'(r_m15) * 31'sd6554;
        fbt    = 18'(fb0) + 18'(fbm >>> 15);
        mixt   = 18'(signed'({2'b00, (i_cfg.mix_q15 > 16'd32768) ? 16'd32768 : i_cfg.mix_q15}))
                 + 18'(r_m15 >>> 2);
        pbig   = 56'(r_prod) * 56'd1618;
    end

    // tap divisions by 125 and 15625 through reciprocal multiplication
    always_comb begin
        qa_full = 45'(r_na) * 45'(RECIP_A);
        qb_full = 59'(r_nb) * 59'(RECIP_B);
    end

    always_comb begin
        tap_a   = (r_qa == '0) ? ADDR_W'(1) :
                  (r_qa > 16'(TAP_MAX)) ? TAP_MAX : r_qa[ADDR_W-1:0];
        tap_b   = (r_qb == '0) ? ADDR_W'(1) :
                  (r_qb > 16'(TAP_MAX)) ? TAP_MAX : r_qb[ADDR_W-1:0];
        raddr_a = r_wp - tap_a;
        raddr_b = r_wp - tap_b;
    end

    always_comb begin
        ps   = 41'(r_s) * 41'sd23170;
        pd   = 41'(r_d) * 41'sd23170;
        na   = 27'(r_x) + 27'(r_pa >>> 15);
        nb   = 27'(r_x) + 27'(r_pb >>> 15);
        pdry = 41'(signed'({1'b0, 16'(17'd32768 - 17'(r_mix))})) * 41'(r_x);
        pwet = 44'(signed'({1'b0, r_mix})) * 44'(r_wet);
        ysum = 45'(pdry) + 45'(pwet);
    end

    always_comb begin
        mem_we = r_clearing || (r_state == S_WR);
        mem_wa = r_clearing ? r_clr_addr : r_wp;
        wd_a   = r_clearing ? '0 : sat_smp(32'(na));
        wd_b   = r_clearing ? '0 : sat_smp(32'(nb));
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            line_a[mem_wa] <= wd_a;
            line_b[mem_wa] <= wd_b;
        end
        r_rda <= line_a[raddr_a];
        r_rdb <= line_b[raddr_b];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (o_qpop) n_state = S_PREP;
            S_PREP: n_state = S_MUL2;
            S_MUL2: n_state = S_MUL3;
            S_MUL3: n_state = S_DIV;
            S_DIV:  n_state = S_RD;
            S_RD:   n_state = S_SD;
            S_SD:   n_state = S_ROT;
            S_ROT:  n_state = S_FB;
            S_FB:   n_state = S_WR;
            S_WR:   n_state = S_OUT;
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_qpop) begin
            r_x   <= i_item.x;
            r_m15 <= i_item.m15;
        end
        if (r_state == S_PREP) begin
            r_p1 <= 27'(size_c) * 27'(scale);
            r_fs <= fs_c;
            r_fb <= (fbt > 18'sd32440) ? 16'sd32440 :
                    (fbt < -18'sd32440) ? -16'sd32440 : 16'(fbt);
            r_mix <= (mixt < 18'sd0) ? 16'd0 :
                     (mixt > 18'sd32768) ? 16'd32768 : 16'(mixt);
        end
        if (r_state == S_MUL2) begin
            r_prod <= 45'(r_p1) * 45'(r_fs);
        end
        // divisors 2^23 * 125 and 2^26 * 15625: shift first, then divide
        if (r_state == S_MUL3) begin
            r_na <= NA_W'(r_prod >> 23);
            r_nb <= NB_W'(pbig >> 26);
        end
        if (r_state == S_DIV) begin
            r_qa <= 16'(qa_full >> QSH_A);
            r_qb <= 16'(qb_full >> QSH_B);
        end
        if (r_state == S_SD) begin
            r_s <= (SMP_W+1)'(r_rda) + (SMP_W+1)'(r_rdb);
            r_d <= (SMP_W+1)'(r_rda) - (SMP_W+1)'(r_rdb);
        end
        if (r_state == S_ROT) begin
            r_sum  <= (SMP_W+1)'(ps >>> 15);
            r_diff <= (SMP_W+1)'(pd >>> 15);
        end
        if (r_state == S_FB) begin
            r_pa <= 41'(r_fb) * 41'(r_diff);
            r_pb <= 41'(r_fb) * 41'(r_sum);
            r_pw <= 42'(27'(r_sum) + 27'(r_diff)) * 42'sd19661;
        end
        if (r_state == S_WR) begin
            r_wet <= 27'(r_pw >>> 15);
        end
        if (r_state == S_OUT && out_free) begin
            r_out <= sat_smp(32'(ysum >>> 15));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_wp       <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == TAP_MAX) begin
                    r_clearing <= 1'b0;
                end
            end
            if (r_state == S_WR) begin
                r_wp <= r_wp + ADDR_W'(1);
            end
            if (r_state == S_OUT && out_free) begin
                r_valid <= 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== hw/rtl/two_line_modulated_diffuser_top.sv =====
// top level of the two-line modulated diffuser: config registers, front and back
//
//  channel   direction  handshake                 payload
//  input     in         push / full               i_audio_in, i_mod_in
//  result    out        pop / empty               o_audio_out
//  config    in         psel penable pwrite pready paddr, pwdata, prdata
//
//  each transaction runs through the back end in order: queue pop, three steps for the
//  stretched size product, one reciprocal multiply for both taps, then read, sum,
//  rotate, feedback, line write and blend, one transaction at a time
//  the front queue holds two transactions, so input keeps flowing while one is in work
//  after reset both delay lines are zeroed in a pass over all 8192 addresses, with full high
//  a waiting result holds the back end in its last step until it is popped
module two_line_modulated_diffuser_top import tlmd_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic signed [SMP_W-1:0] i_audio_in,
    input  logic signed [SMP_W-1:0] i_mod_in,
    output logic                    empty,
    input  logic                    pop,
    output logic signed [SMP_W-1:0] o_audio_out,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [3:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    t_cfg        r_cfg;
    logic        cfg_we;
    logic        qfull;
    logic        qvalid;
    logic        qpop;
    logic        clearing;
    logic        out_valid;
    t_item       item;

    assign pready = 1'b1;
    // register write lands in the access phase
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.size_ms_q4     <= 10'd160;
            r_cfg.sample_rate_hz <= 18'd48000;
            r_cfg.feedback_q15   <= 16'sd0;
            r_cfg.mix_q15        <= 16'd16384;
        end else if (cfg_we) begin
            unique case (paddr[3:2])
                REG_SIZE: r_cfg.size_ms_q4     <= pwdata[9:0];
                REG_FS:   r_cfg.sample_rate_hz <= pwdata[17:0];
                REG_FB:   r_cfg.feedback_q15   <= signed'(pwdata[15:0]);
                REG_MIX:  r_cfg.mix_q15        <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // readback of the raw register values
    always_comb begin
        unique case (paddr[3:2])
            REG_SIZE: prdata = 32'(r_cfg.size_ms_q4);
            REG_FS:   prdata = 32'(r_cfg.sample_rate_hz);
            REG_FB:   prdata = 32'(unsigned'(r_cfg.feedback_q15));
            REG_MIX:  prdata = 32'(r_cfg.mix_q15);
            default:  prdata = '0;
        endcase
    end

    // input is held off while the lines are being cleared
    assign full  = qfull || clearing;
    assign empty = !out_valid;

    tlmd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push && !clearing),
        .i_audio_in (i_audio_in),
        .i_mod_in   (i_mod_in),
        .o_qfull    (qfull),
        .o_qvalid   (qvalid),
        .o_item     (item),
        .i_qpop     (qpop)
    );

    tlmd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_qvalid    (qvalid),
        .i_item      (item),
        .o_qpop      (qpop),
        .o_clearing  (clearing),
        .o_valid     (out_valid),
        .o_audio_out (o_audio_out),
        .i_pop       (pop && out_valid)
    );

endmodule

// ===== hw/rtl/tlmd_checker.sv =====
// port-level checks of the diffuser top level, bound to it
module tlmd_checker import tlmd_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    full,
    input logic                    empty,
    input logic                    pop,
    input logic                    pready,
    input logic signed [SMP_W-1:0] o_audio_out
);

    // reset starts the line clearing pass, so input is refused right after
    a_full_after_rst: assert property (@(posedge i_clk) !i_rst_n |=> full)
        else $error("full low right after reset");

    // no result can be waiting right after reset
    a_empty_after_rst: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result pending right after reset");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready dropped");

    // a waiting result that is not popped stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_audio_out))
        else $error("waiting result changed or vanished");

endmodule

bind two_line_modulated_diffuser_top tlmd_checker u_tlmd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .pready      (pready),
    .o_audio_out (o_audio_out)
);

// ===== tb/sv/two_line_modulated_diffuser_top_tb.sv =====
// self-checking testbench of the two-line modulated diffuser top level
module two_line_modulated_diffuser_top_tb;
    import tlmd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 40000;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    push;
    logic                    full;
    logic signed [SMP_W-1:0] i_audio_in;
    logic signed [SMP_W-1:0] i_mod_in;
    logic                    empty;
    logic                    pop;
    logic signed [SMP_W-1:0] o_audio_out;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [3:0]              paddr;
    logic [31:0]             pwdata;
    logic [31:0]             prdata;
    logic                    pready;

    two_line_modulated_diffuser_top uut (.*);

    // predictor state: own copy of both delay lines, write index and registers
    logic signed [SMP_W-1:0] pred_line_a [LINE_DEPTH];
    logic signed [SMP_W-1:0] pred_line_b [LINE_DEPTH];
    int unsigned             pred_wpos;
    logic [9:0]              cfg_size;
    logic [17:0]             cfg_fs;
    logic [15:0]             cfg_fb;
    logic [15:0]             cfg_mix;

    logic signed [SMP_W-1:0] expected_out [$];
    int                      err_count;
    int                      idle_cycles;
    int                      results_seen;
    int                      items_sent;
    int                      pop_cycle;
    bit                      pop_stall_en;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // floor division by a power of two (arithmetic shift rounds toward minus infinity)
    function automatic longint floor_shr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint clamp_l(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // compute the expected blend for one sample and update the predicted lines
    function automatic logic signed [SMP_W-1:0] diffuse_sample(
        input logic signed [SMP_W-1:0] x_in, input logic signed [SMP_W-1:0] mod_in);
        longint x, m15, size, fs, prod, tap_a, tap_b, fb, mix, a, b, sm, df, wet, y;
        longint smax, smin;
        int unsigned ia, ib;
        smax = (longint'(1) <<< (SMP_W - 1)) - 1;
        smin = -(longint'(1) <<< (SMP_W - 1));
        x     = x_in;
        m15   = floor_shr(longint'(mod_in), MOD_SHIFT);
        size  = clamp_l(longint'(cfg_size), 8, 960);
        fs    = clamp_l(longint'(cfg_fs), 1, 192000);
        prod  = size * (65536 + m15) * fs;
        tap_a = prod / (64'd16 * 64'd65536 * 64'd1000);
        tap_b = (prod * 1618) / (64'd16 * 64'd65536 * 64'd1000000);
        tap_a = clamp_l(tap_a, 1, LINE_DEPTH - 1);
        tap_b = clamp_l(tap_b, 1, LINE_DEPTH - 1);
        fb    = clamp_l(longint'($signed(cfg_fb)), -32440, 32440);
        fb    = clamp_l(fb + floor_shr(m15 * 6554, 15), -32440, 32440);
        mix   = clamp_l(longint'(cfg_mix), 0, 32768);
        mix   = clamp_l(mix + floor_shr(m15, 2), 0, 32768);
        ia    = (pred_wpos + LINE_DEPTH - int'(tap_a)) % LINE_DEPTH;
        ib    = (pred_wpos + LINE_DEPTH - int'(tap_b)) % LINE_DEPTH;
        a     = pred_line_a[ia];
        b     = pred_line_b[ib];
        sm    = floor_shr((a + b) * 23170, 15);
        df    = floor_shr((a - b) * 23170, 15);
        pred_line_a[pred_wpos] = SMP_W'(clamp_l(x + floor_shr(fb * df, 15), smin, smax));
        pred_line_b[pred_wpos] = SMP_W'(clamp_l(x + floor_shr(fb * sm, 15), smin, smax));
        wet   = floor_shr((sm + df) * 19661, 15);
        y     = floor_shr((32768 - mix) * x + mix * wet, 15);
        pred_wpos = (pred_wpos + 1) % LINE_DEPTH;
        return SMP_W'(clamp_l(y, smin, smax));
    endfunction

    // one apb write: setup, access, then an idle phase, only while the block is idle
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(idx) << 2;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // mirror the register, upper bits dropped
        case (idx)
            REG_SIZE: cfg_size = val[9:0];
            REG_FS:   cfg_fs   = val[17:0];
            REG_FB:   cfg_fb   = val[15:0];
            REG_MIX:  cfg_mix  = val[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // send one sample transaction and queue its expected result; push is left high
    task automatic send_sample(input logic [SMP_W-1:0] x, input logic [SMP_W-1:0] m);
        push       <= 1'b1;
        i_audio_in <= x;
        i_mod_in   <= m;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        expected_out.push_back(diffuse_sample(x, m));
        items_sent++;
    endtask

    // burst of random samples with random gaps; push stays high within a burst
    task automatic send_burst(input int n, input bit full_range_mod);
        logic [SMP_W-1:0] x, m;
        int burst;
        burst = 0;
        for (int k = 0; k < n; k++) begin
            x = SMP_W'($urandom);
            case ($urandom_range(0, 5))
                0: x = {1'b0, {(SMP_W-1){1'b1}}};
                1: x = {1'b1, {(SMP_W-1){1'b0}}};
                2: x = SMP_W'($signed($urandom_range(0, 4000)) - 2000);
                default: ;
            endcase
            m = full_range_mod ? SMP_W'($urandom) : SMP_W'($urandom_range(0, 65535) - 32768);
            if ($urandom_range(0, 9) == 0) m = $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
            push       <= 1'b1;
            i_audio_in <= x;
            i_mod_in   <= m;
            @(posedge i_clk);
            while (full) @(posedge i_clk);
            expected_out.push_back(diffuse_sample(x, m));
            items_sent++;
            if (burst == 0) burst = $urandom_range(1, 12);
            burst--;
            // gap between bursts: lower push, wait, then raise again next transaction
            if (burst == 0 && $urandom_range(0, 1)) begin
                push <= 1'b0;
                repeat ($urandom_range(1, 80)) @(posedge i_clk);
            end
        end
        push <= 1'b0;
    endtask

    // wait until every expected result has arrived, plus the back-end latency
    task automatic drain;
        while (expected_out.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic test_directed;
        logic [SMP_W-1:0] vals [6];
        vals = '{24'h7fffff, 24'h800000, 24'h000000, 24'h000001, 24'hffffff, 24'h400000};
        // extremes of both fields, modulation at full scale both ways
        foreach (vals[i]) send_sample(vals[i], 24'h000000);
        foreach (vals[i]) send_sample(vals[i], vals[i]);
        send_sample(24'h7fffff, 24'h800000);
        send_sample(24'h800000, 24'h7fffff);
        push <= 1'b0;
        drain();
    endtask

    // each register at an extreme of its range and beyond it on either side, mix above only
    task automatic test_registers;
        write_reg(REG_SIZE, 32'd8);
        write_reg(REG_FS, 32'd1);
        write_reg(REG_FB, 32'hffff_8148);
        write_reg(REG_MIX, 32'd0);
        send_burst(40, 1'b1);
        drain();
        write_reg(REG_SIZE, 32'h3ff);
        write_reg(REG_FS, 32'h3ffff);
        write_reg(REG_FB, 32'h7fff);
        write_reg(REG_MIX, 32'hffff);
        send_burst(40, 1'b1);
        drain();
        write_reg(REG_SIZE, 32'd0);
        write_reg(REG_FS, 32'd0);
        write_reg(REG_FB, 32'h8000);
        write_reg(REG_MIX, 32'd32768);
        send_burst(40, 1'b1);
        drain();
    endtask

    // random settings, often at low sample rates with short taps so the feedback loop builds up content
    task automatic test_random;
        for (int p = 0; p < 10; p++) begin
            write_reg(REG_SIZE, $urandom_range(0, 1023) | ($urandom_range(0, 1) << 12));
            write_reg(REG_FS, $urandom_range(0, 1) ? $urandom_range(1, 8000)
                                                   : $urandom_range(0, 262143));
            write_reg(REG_FB, $urandom);
            write_reg(REG_MIX, $urandom_range(0, 65535));
            send_burst(145, $urandom_range(0, 1));
            // the sender holds off until every result is back
            drain();
        end
    endtask

    // result checker: pop with its own stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_out.size() == 0) begin
                    $error("unexpected audio_out transaction: %0d", o_audio_out);
                    err_count++;
                end else begin
                    logic signed [SMP_W-1:0] exp_v;
                    exp_v = expected_out.pop_front();
                    if (o_audio_out !== exp_v) begin
                        $error("audio_out mismatch: expected %0d actual %0d", exp_v, o_audio_out);
                        err_count++;
                    end
                end
                results_seen++;
            end
            pop_cycle++;
            pop <= pop_stall_en ? ($urandom_range(0, 3) != 0 && pop_cycle % 37 > 3)
                                : 1'b1;
        end
    end

    // watchdog over cycles with no accepted transaction
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d results pending", expected_out.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        push = 1'b0; i_audio_in = '0; i_mod_in = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        err_count = 0; idle_cycles = 0; results_seen = 0; items_sent = 0;
        pop_cycle = 0;
        pop_stall_en = 1'b0;
        pred_wpos = 0;
        foreach (pred_line_a[i]) begin
            pred_line_a[i] = '0;
            pred_line_b[i] = '0;
        end
        cfg_size = 10'd160; cfg_fs = 18'd48000; cfg_fb = 16'd0; cfg_mix = 16'd16384;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        pop_stall_en = 1'b1;
        test_registers();
        test_random();
        $display("sent %0d samples and checked %0d results over register extremes",
                 items_sent, results_seen);
        $display("and random settings, with input gaps and output stalls");
        if (err_count == 0 && expected_out.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/tlmd_pkg.sv
hw/rtl/tlmd_front.sv
hw/rtl/tlmd_back.sv
hw/rtl/two_line_modulated_diffuser_top.sv
hw/rtl/tlmd_checker.sv
tb/sv/two_line_modulated_diffuser_top_tb.sv
